FILE: rtl/core/tlbpt_pkg.sv
// tlbpt_pkg: shared constants for the tlb page translation block
// no dependencies; imported by every module of the block

package tlbpt_pkg;

   localparam int ADDR_W          = 16;
   localparam int COUNT_W         = 32;
   localparam int TLB_ENTRIES_DEF = 16;
   localparam int PAGE_COUNT_DEF  = 256;
   localparam int OFFSET_BITS_DEF = 8;

   // sequencer codes of the top level
   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

endpackage

FILE: rtl/core/tlb_page_translate.sv
// tlb_page_translate: top level of the page translation block
// depends on tlbpt_pkg, tlbpt_page_map and tlbpt_tlb
//
// usage
//   req_ channel carries one logical address per item; the upper bits
//   (modulo the page count) are the page, the low OFFSET_BITS the offset.
//   rsp_ channel returns one item per request: physical address, tlb hit
//   and page fault flags and three saturating running counts.
// sequence
//   the accept cycle reads the page map memory; the execute state then
//   runs the tlb match, allocates a frame on a fault and, once the output
//   is free, writes map, tlb and counts back and loads the output register.
//   a new item is accepted only from the idle state, so the block takes no
//   new request until the last one has left its execute state.
// reset
//   synchronous, active high; clears tlb and page map valid bits, the
//   fifo pointer, the frame allocator and all counts. no clearing pass.
// stall
//   while rsp_ready is low a waiting result holds; one further item may
//   be accepted and parks in its execute cycle until the output frees.

module tlb_page_translate #(
   parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
   parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
   parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [tlbpt_pkg::ADDR_W-1:0] req_logical_address,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tlbpt_pkg::ADDR_W-1:0] rsp_physical_address,
   output logic                         rsp_tlb_hit,
   output logic                         rsp_page_fault,
   output logic [tlbpt_pkg::COUNT_W-1:0] rsp_hit_count,
   output logic [tlbpt_pkg::COUNT_W-1:0] rsp_fault_count,
   output logic [tlbpt_pkg::COUNT_W-1:0] rsp_access_count
);
   import tlbpt_pkg::*;

   localparam int PAGE_BITS = $clog2(PAGE_COUNT);
   localparam int RAW_W     = (OFFSET_BITS < ADDR_W) ? ADDR_W - OFFSET_BITS : 0;
   localparam int RAW_VW    = (RAW_W > 0) ? RAW_W : 1;
   // compare-subtract steps needed to bring the raw page below PAGE_COUNT
   localparam int MOD_STEPS = (RAW_W >= PAGE_BITS) ? RAW_W - PAGE_BITS + 1 : 0;

   logic                   state_ff;
   logic                   state_in;
   logic                   accept;
   logic                   finish;
   logic                   out_free;

   logic [RAW_VW-1:0]      raw_page;
   logic [RAW_VW:0]        rem;
   logic [PAGE_BITS-1:0]   req_page;

   logic [PAGE_BITS-1:0]   page_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [PAGE_BITS-1:0]   next_frame_ff;
   logic [PAGE_BITS-1:0]   next_frame_in;

   logic                   map_valid;
   logic [PAGE_BITS-1:0]   map_frame;
   logic                   tlb_hit;
   logic [PAGE_BITS-1:0]   tlb_frame;

   logic                   fault;
   logic [PAGE_BITS-1:0]   frame;

   logic [COUNT_W-1:0]     hit_total_ff;
   logic [COUNT_W-1:0]     fault_total_ff;
   logic [COUNT_W-1:0]     access_total_ff;
   logic [COUNT_W-1:0]     hit_total_in;
   logic [COUNT_W-1:0]     fault_total_in;
   logic [COUNT_W-1:0]     access_total_in;

   logic                   rsp_valid_ff;
   logic [ADDR_W-1:0]      phys_ff;
   logic                   hit_flag_ff;
   logic                   fault_flag_ff;

   // one item in execution at a time; a new item is taken only between items
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == S_EXEC) && out_free;

   // page number modulo the page count by restoring compare and subtract
   assign raw_page = RAW_VW'(req_logical_address >> OFFSET_BITS);

   always_comb begin
      rem = {1'b0, raw_page};
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if (rem >= (RAW_VW + 1)'(PAGE_COUNT << k)) begin
            rem = rem - (RAW_VW + 1)'(PAGE_COUNT << k);
         end
      end
      req_page = PAGE_BITS'(rem);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff   <= req_page;
         offset_ff <= req_logical_address[OFFSET_BITS-1:0];
      end
   end

   tlbpt_page_map #(
      .PAGE_COUNT (PAGE_COUNT),
      .PAGE_BITS  (PAGE_BITS)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_page  (req_page),
      .rd_valid (map_valid),
      .rd_frame (map_frame),
      .wr_en    (finish && fault),
      .wr_page  (page_ff),
      .wr_frame (next_frame_ff)
   );

   tlbpt_tlb #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .PAGE_BITS   (PAGE_BITS)
   ) u_tlb (
      .clock      (clock),
      .reset      (reset),
      .look_page  (page_ff),
      .look_hit   (tlb_hit),
      .look_frame (tlb_frame),
      .fill_en    (finish && !tlb_hit),
      .fill_page  (page_ff),
      .fill_frame (frame)
   );

   // frame choice: tlb, then the map, then a fresh frame on a fault
   assign fault = !tlb_hit && !map_valid;
   assign frame = tlb_hit ? tlb_frame : (map_valid ? map_frame : next_frame_ff);

   assign next_frame_in = (next_frame_ff == PAGE_BITS'(PAGE_COUNT - 1)) ?
                          '0 : next_frame_ff + 1'b1;

   // saturating counts
   assign access_total_in = (&access_total_ff) ? access_total_ff : access_total_ff + 1'b1;
   assign hit_total_in    = (tlb_hit && !(&hit_total_ff)) ? hit_total_ff + 1'b1 : hit_total_ff;
   assign fault_total_in  = (fault && !(&fault_total_ff)) ?
                            fault_total_ff + 1'b1 : fault_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         next_frame_ff   <= '0;
         hit_total_ff    <= '0;
         fault_total_ff  <= '0;
         access_total_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            rsp_valid_ff    <= 1'b1;
            access_total_ff <= access_total_in;
            hit_total_ff    <= hit_total_in;
            fault_total_ff  <= fault_total_in;
            if (fault) begin
               next_frame_ff <= next_frame_in;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output register, loaded as the item completes
   always_ff @(posedge clock) begin
      if (finish) begin
         phys_ff       <= ADDR_W'({frame, offset_ff});
         hit_flag_ff   <= tlb_hit;
         fault_flag_ff <= fault;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = phys_ff;
   assign rsp_tlb_hit          = hit_flag_ff;
   assign rsp_page_fault       = fault_flag_ff;
   assign rsp_hit_count        = hit_total_ff;
   assign rsp_fault_count      = fault_total_ff;
   assign rsp_access_count     = access_total_ff;

endmodule

FILE: rtl/core/tlbpt_page_map.sv
// tlbpt_page_map: page-to-frame memory with registered read
// depends on tlbpt_pkg; per-entry valid bits in flip-flops cleared by reset

module tlbpt_page_map #(
   parameter int PAGE_COUNT = tlbpt_pkg::PAGE_COUNT_DEF,
   parameter int PAGE_BITS  = $clog2(tlbpt_pkg::PAGE_COUNT_DEF)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [PAGE_BITS-1:0] rd_page,
   output logic                 rd_valid,
   output logic [PAGE_BITS-1:0] rd_frame,
   input  logic                 wr_en,
   input  logic [PAGE_BITS-1:0] wr_page,
   input  logic [PAGE_BITS-1:0] wr_frame
);
   import tlbpt_pkg::*;

   logic [PAGE_BITS-1:0] map_mem [PAGE_COUNT];
   logic [PAGE_COUNT-1:0] valid_ff;
   logic [PAGE_BITS-1:0] rd_frame_ff;
   logic                 rd_valid_ff;

   // frame storage, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_page] <= wr_frame;
      end
      if (rd_en) begin
         rd_frame_ff <= map_mem[rd_page];
         rd_valid_ff <= valid_ff[rd_page];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_page] <= 1'b1;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_frame = rd_frame_ff;

endmodule

FILE: rtl/core/tlbpt_tlb.sv
// tlbpt_tlb: fully associative tlb with fifo replacement
// depends on tlbpt_pkg; lowest matching valid entry wins

module tlbpt_tlb #(
   parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
   parameter int PAGE_BITS   = $clog2(tlbpt_pkg::PAGE_COUNT_DEF)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [PAGE_BITS-1:0] look_page,
   output logic                 look_hit,
   output logic [PAGE_BITS-1:0] look_frame,
   input  logic                 fill_en,
   input  logic [PAGE_BITS-1:0] fill_page,
   input  logic [PAGE_BITS-1:0] fill_frame
);
   import tlbpt_pkg::*;

   localparam int SLOT_BITS = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

   logic [PAGE_BITS-1:0]   page_ff  [TLB_ENTRIES];
   logic [PAGE_BITS-1:0]   frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] valid_ff;
   logic [SLOT_BITS-1:0]   slot_ff;
   logic [SLOT_BITS-1:0]   slot_in;
   logic [SLOT_BITS-1:0]   match_idx;
   logic                   match_any;

   // priority match, scanned high to low so the lowest entry is kept
   always_comb begin
      match_any = 1'b0;
      match_idx = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (page_ff[i] == look_page)) begin
            match_any = 1'b1;
            match_idx = SLOT_BITS'(i);
         end
      end
   end

   assign look_hit   = match_any;
   assign look_frame = frame_ff[match_idx];

   assign slot_in = (slot_ff == SLOT_BITS'(TLB_ENTRIES - 1)) ? '0 : slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (fill_en) begin
         page_ff[slot_ff]  <= fill_page;
         frame_ff[slot_ff] <= fill_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         slot_ff  <= '0;
      end else if (fill_en) begin
         valid_ff[slot_ff] <= 1'b1;
         slot_ff           <= slot_in;
      end
   end

endmodule
